>>> hw/rtl/one_wire_tick_program_sequencer_defines.svh
// Assertion macros shared by the tick program sequencer RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ONE_WIRE_TICK_PROGRAM_SEQUENCER_DEFINES_SVH
`define ONE_WIRE_TICK_PROGRAM_SEQUENCER_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked at every clock edge except while reset is high.
`define OWTPS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define OWTPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OWTPS_ASSERT(lbl, clk, rst, prop, msg)
`define OWTPS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> hw/rtl/owtps_pkg.sv
// Package of the tick program sequencer: codes, modes, command and status types.
// Depends on nothing; used by the queue, front, back and top-level modules.
`timescale 1ns / 1ps
`default_nettype none
package owtps_pkg;

   localparam int PROG_DEPTH_DEF  = 256;
   localparam int QUEUE_DEPTH_DEF = 2;
   localparam int ADDR_W          = 8;
   localparam int BYTE_W          = 8;
   localparam int TICKS_W         = 16;

   // Instruction modes held in the mode byte.
   localparam logic [BYTE_W-1:0] MODE_END     = 8'h00;
   localparam logic [BYTE_W-1:0] MODE_PULL    = 8'h01;
   localparam logic [BYTE_W-1:0] MODE_RELEASE = 8'h02;
   localparam logic [BYTE_W-1:0] MODE_SAMPLE  = 8'h03;

   localparam logic [TICKS_W-1:0] COUNT_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_START = 2'd1,
      OP_TICK  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      BK_EXEC,
      BK_FETCH_MODE,
      BK_FETCH_HI,
      BK_FETCH_LO
   } back_state_type;

   // A classified command as it sits in the queue.
   typedef struct packed {
      op_type              op;
      logic                wr_ok;
      logic [ADDR_W-1:0]   addr;
      logic [BYTE_W-1:0]   data;
      logic                level;
   } cmd_type;

   typedef struct packed {
      logic fetching;
      logic running;
   } back_stat_type;

endpackage
`default_nettype wire

>>> hw/rtl/owtps_if.sv
// Handshake interfaces of the tick program sequencer: request and response channels.
// Depends on nothing; used by the front, back and top-level modules.
`timescale 1ns / 1ps
`default_nettype none
interface owtps_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] address;
   logic [7:0] data;
   logic       line_level;

   modport source (output valid, opcode, address, data, line_level, input ready);
   modport sink   (input valid, opcode, address, data, line_level, output ready);
endinterface

interface owtps_rsp_if;
   logic valid;
   logic ready;
   logic line_released;
   logic busy_res;
   logic finished;
   logic presence;

   modport source (output valid, line_released, busy_res, finished, presence, input ready);
   modport sink   (input valid, line_released, busy_res, finished, presence, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/owtps_queue.sv
// Small command queue between the front and the back of the sequencer.
// Depends on owtps_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none
module owtps_queue
   import owtps_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire cmd_type                    push_cmd,
   input  wire logic                       pop,
   output      cmd_type                    pop_cmd,
   output      logic                       full,
   output      logic                       empty,
   output      logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   cmd_type         entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign pop_cmd = entry_ff[rd_ptr_ff];
   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;

endmodule
`default_nettype wire

>>> hw/rtl/owtps_front.sv
// Front of the sequencer: takes request transactions and classifies them into commands.
// Depends on owtps_pkg and the request interface in owtps_if.sv.
`timescale 1ns / 1ps
`default_nettype none
module owtps_front
   import owtps_pkg::*;
#(
   parameter int PROGRAM_DEPTH = PROG_DEPTH_DEF
) (
   owtps_req_if.sink     req_chan,
   input  wire logic     queue_full,
   output      logic     push,
   output      cmd_type  push_cmd
);

   logic [11:0] start_rem;

   // Start address modulo the program depth: four restoring subtract steps cover
   // every 8-bit address for depths of sixteen and above.
   always_comb begin
      start_rem = {4'b0, req_chan.address};
      for (int k = 3; k >= 0; k--) begin
         if (start_rem >= (12'(PROGRAM_DEPTH) << k)) begin
            start_rem = start_rem - (12'(PROGRAM_DEPTH) << k);
         end
      end
   end

   always_comb begin
      push_cmd.op    = op_type'(req_chan.opcode);
      push_cmd.wr_ok = ({1'b0, req_chan.address} < 9'(PROGRAM_DEPTH));
      push_cmd.data  = req_chan.data;
      push_cmd.level = req_chan.line_level;
      if (push_cmd.op == OP_START) begin
         push_cmd.addr = start_rem[ADDR_W-1:0];
      end else begin
         push_cmd.addr = req_chan.address;
      end
   end

   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;

endmodule
`default_nettype wire

>>> hw/rtl/owtps_back.sv
// Back of the sequencer: program store, instruction fetch, tick execution, response register.
// Depends on owtps_pkg and the response interface in owtps_if.sv.
`timescale 1ns / 1ps
`default_nettype none
module owtps_back
   import owtps_pkg::*;
#(
   parameter int PROGRAM_DEPTH = PROG_DEPTH_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           cmd_valid,
   input  wire cmd_type        cmd,
   output      logic           cmd_pop,
   owtps_rsp_if.source         rsp_chan,
   output      back_stat_type  stat
);

   localparam int AW = $clog2(PROGRAM_DEPTH);

   logic [BYTE_W-1:0]  prog_mem [PROGRAM_DEPTH];
   logic [BYTE_W-1:0]  rd_data_ff;

   back_state_type     state_ff, state_in;
   logic [AW-1:0]      ptr_ff, ptr_in, ptr_next;
   logic               running_ff, running_in;
   logic               loaded_ff, loaded_in;
   logic [BYTE_W-1:0]  mode_ff, mode_in;
   logic [TICKS_W-1:0] ticks_ff, ticks_in, ticks_dec;
   logic [TICKS_W-1:0] low_ff, low_in;
   logic [TICKS_W-1:0] high_ff, high_in;
   logic               line_ff, line_in;
   logic               result_ff, result_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_line_ff, rsp_busy_ff, rsp_fin_ff, rsp_pres_ff;

   logic out_free, take, emit, done, rd_en, wr_en;

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign take      = (state_ff == BK_EXEC) && cmd_valid && out_free;
   assign ptr_next  = (ptr_ff == AW'(PROGRAM_DEPTH-1)) ? '0 : ptr_ff + 1'b1;
   assign ticks_dec = ticks_ff - 1'b1;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_EXEC: begin
            if (take && cmd.op == OP_TICK && running_ff && !loaded_ff) begin
               state_in = BK_FETCH_MODE;
            end
         end
         BK_FETCH_MODE: state_in = BK_FETCH_HI;
         BK_FETCH_HI:   state_in = BK_FETCH_LO;
         BK_FETCH_LO: begin
            if (out_free) begin
               state_in = BK_EXEC;
            end
         end
         default: state_in = BK_EXEC;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      ptr_in     = ptr_ff;
      running_in = running_ff;
      loaded_in  = loaded_ff;
      mode_in    = mode_ff;
      ticks_in   = ticks_ff;
      low_in     = low_ff;
      high_in    = high_ff;
      line_in    = line_ff;
      result_in  = result_ff;
      emit       = 1'b0;
      done       = 1'b0;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      case (state_ff)
         BK_EXEC: begin
            if (take) begin
               case (cmd.op)
                  OP_WRITE: begin
                     wr_en = cmd.wr_ok;
                     emit  = 1'b1;
                  end
                  OP_START: begin
                     ptr_in     = cmd.addr[AW-1:0];
                     running_in = 1'b1;
                     loaded_in  = 1'b0;
                     emit       = 1'b1;
                  end
                  OP_TICK: begin
                     if (!running_ff) begin
                        emit = 1'b1;
                     end else if (!loaded_ff) begin
                        rd_en  = 1'b1;
                        ptr_in = ptr_next;
                     end else begin
                        emit = 1'b1;
                        case (mode_ff)
                           MODE_END: begin
                              result_in  = (high_ff > low_ff);
                              running_in = 1'b0;
                              done       = 1'b1;
                           end
                           MODE_PULL:    line_in = 1'b0;
                           MODE_RELEASE: line_in = 1'b1;
                           MODE_SAMPLE: begin
                              line_in = 1'b1;
                              if (!cmd.level) begin
                                 if (low_ff != COUNT_MAX) low_in = low_ff + 1'b1;
                              end else begin
                                 if (high_ff != COUNT_MAX) high_in = high_ff + 1'b1;
                              end
                           end
                           default: ;
                        endcase
                        ticks_in  = ticks_dec;
                        loaded_in = !((ticks_dec == '0) || done);
                     end
                  end
                  default: emit = 1'b1;
               endcase
            end
         end
         BK_FETCH_MODE: begin
            mode_in = rd_data_ff;
            rd_en   = 1'b1;
            ptr_in  = ptr_next;
         end
         BK_FETCH_HI: begin
            ticks_in = {rd_data_ff, ticks_ff[BYTE_W-1:0]};
            rd_en    = 1'b1;
            ptr_in   = ptr_next;
         end
         BK_FETCH_LO: begin
            if (out_free) begin
               ticks_in  = {ticks_ff[TICKS_W-1:BYTE_W], rd_data_ff};
               loaded_in = 1'b1;
               emit      = 1'b1;
               if (mode_ff == MODE_SAMPLE) begin
                  low_in  = '0;
                  high_in = '0;
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_EXEC;
         ptr_ff       <= '0;
         running_ff   <= 1'b0;
         loaded_ff    <= 1'b0;
         mode_ff      <= '0;
         ticks_ff     <= '0;
         low_ff       <= '0;
         high_ff      <= '0;
         line_ff      <= 1'b1;
         result_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         running_ff   <= running_in;
         loaded_ff    <= loaded_in;
         mode_ff      <= mode_in;
         ticks_ff     <= ticks_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         line_ff      <= line_in;
         result_ff    <= result_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_line_ff <= line_in;
         rsp_busy_ff <= running_in;
         rsp_fin_ff  <= done;
         rsp_pres_ff <= result_in;
      end
   end

   // Program store: one write port, one read port with registered data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         prog_mem[cmd.addr[AW-1:0]] <= cmd.data;
      end
      if (rd_en) begin
         rd_data_ff <= prog_mem[ptr_ff];
      end
   end

   assign cmd_pop                = take;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.line_released = rsp_line_ff;
   assign rsp_chan.busy_res      = rsp_busy_ff;
   assign rsp_chan.finished      = rsp_fin_ff;
   assign rsp_chan.presence      = rsp_pres_ff;
   assign stat.fetching          = (state_ff != BK_EXEC);
   assign stat.running           = running_ff;

endmodule
`default_nettype wire

>>> hw/rtl/one_wire_tick_program_sequencer.sv
// Top level of the tick program sequencer: front, command queue and back joined up.
// Depends on owtps_pkg, owtps_if.sv, owtps_queue, owtps_front, owtps_back and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "one_wire_tick_program_sequencer_defines.svh"
// The sequencer runs a byte program that drives and samples a single bus line, one timer
// tick at a time, and answers every request transaction with exactly one response
// transaction carrying the line drive, the busy flag, a finished pulse and the last
// presence result. Each instruction is three bytes: mode, then a 16-bit tick count high
// byte first. The front takes a request transaction in every cycle while the command queue
// has room, so requests keep flowing while a response waits to be taken. In the back, a
// write, a start, a no-operation, a tick while idle and an executing tick need no fetch;
// the tick that fetches the next instruction passes the mode, high and low fetch states
// that take in three reads of the program store, whose read data is registered. The program store
// is not cleared at reset: a fetch from a byte that was never written returns unspecified
// values, so a program must be written before it is started.
module one_wire_tick_program_sequencer
   import owtps_pkg::*;
#(
   parameter int PROGRAM_DEPTH = PROG_DEPTH_DEF,
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
   input  wire logic      clock,
   input  wire logic      reset,
   owtps_req_if.sink      req_chan,
   owtps_rsp_if.source    rsp_chan
);

   localparam int QCW = $clog2(QUEUE_DEPTH+1);

   cmd_type        push_cmd, pop_cmd;
   logic           push, pop;
   logic           q_full, q_empty;
   logic [QCW-1:0] q_count;
   back_stat_type  back_stat;

   // The front decodes each transaction and reduces a start address to the store depth.
   owtps_front #(
      .PROGRAM_DEPTH (PROGRAM_DEPTH)
   ) u_front (
      .req_chan   (req_chan),
      .queue_full (q_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // The queue lets the front carry on while the back is fetching or the response stalls.
   owtps_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .full     (q_full),
      .empty    (q_empty),
      .count    (q_count)
   );

   // The back executes commands in order and owns the program store and all run state.
   owtps_back #(
      .PROGRAM_DEPTH (PROGRAM_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!q_empty),
      .cmd       (pop_cmd),
      .cmd_pop   (pop),
      .rsp_chan  (rsp_chan),
      .stat      (back_stat)
   );

   // The queue never holds more than its depth.
   `OWTPS_ASSERT(a_queue_bound, clock, reset, q_count <= QCW'(QUEUE_DEPTH), "queue overfilled")
   // A run that reports finished is no longer busy in the same transaction.
   `OWTPS_ASSERT(a_fin_idle, clock, reset, (rsp_chan.valid && rsp_chan.finished) |-> !rsp_chan.busy_res, "finished while busy")
   // An instruction fetch only happens inside a running program.
   `OWTPS_ASSERT(a_fetch_run, clock, reset, back_stat.fetching |-> back_stat.running, "fetch while not running")
   // Nothing is queued and nothing is offered in the cycle after a reset cycle.
   `OWTPS_ASSERT_ALWAYS(a_reset_clean, clock, reset |=> (q_count == '0 && !rsp_chan.valid), "state left after reset")

endmodule
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the one-wire tick program sequencer.
// Depends on owtps_pkg, the owtps_req_if and owtps_rsp_if interfaces and the sequencer RTL.
module tb_top;
   import owtps_pkg::*;

   // The response transaction as the predictor sees it, one bit per field.
   typedef struct packed {
      logic line_released;
      logic busy_res;
      logic finished;
      logic presence;
   } line_status_type;

   // One row of the bring-up script. Where the outcome is plain from the row alone
   // (straight after reset, a start from idle) it is written into the row and takes the
   // place of the prediction; elsewhere the predictor supplies it.
   typedef struct packed {
      op_type          op;
      logic [7:0]      addr;
      logic [7:0]      data;
      logic            level;
      logic            typed;
      line_status_type status;
   } script_row_type;

   localparam int HALF_PERIOD_NS = 6;
   localparam int RESET_CYCLES   = 4;
   localparam int STALL_LIMIT    = 2000;
   localparam int DRAIN_CYCLES   = 32;
   localparam int REPORT_LIMIT   = 40;
   localparam int PHASE_ITEMS    = 500;
   localparam int EPISODE_STEPS  = 700;
   localparam int BRING_UP_ROWS  = 25;

   localparam line_status_type IDLE_STATUS    = '{1'b1, 1'b0, 1'b0, 1'b0};
   localparam line_status_type STARTED_STATUS = '{1'b1, 1'b1, 1'b0, 1'b0};
   localparam line_status_type NO_STATUS      = '{1'b0, 1'b0, 1'b0, 1'b0};

   logic clock = 1'b0;
   logic reset = 1'b1;

   owtps_req_if req_bus ();
   owtps_rsp_if rsp_bus ();

   one_wire_tick_program_sequencer i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #HALF_PERIOD_NS clock = ~clock;

   // ---------------------------------------------------------------------------------
   // Shadow of the sequencer. It is advanced once for every request transaction that the
   // block accepts, in the order of acceptance, and the stimulus reads it to decide what
   // to send next: notably, it never lets a fetch reach a program byte that was not
   // written, since the store comes out of reset holding unspecified values.
   // ---------------------------------------------------------------------------------
   logic [7:0]  prog_mem     [PROG_DEPTH_DEF];
   bit          prog_written [PROG_DEPTH_DEF];
   logic [7:0]  pc           = '0;
   logic        run_active   = 1'b0;
   logic        instr_held   = 1'b0;
   logic [7:0]  mode_reg     = '0;
   logic [15:0] tick_count   = '0;
   logic [15:0] low_cnt      = '0;
   logic [15:0] high_cnt     = '0;
   logic        line_rel     = 1'b1;
   logic        presence_bit = 1'b0;

   line_status_type expected_status_q [$];

   int req_idle_pct   = 0;
   int rsp_idle_pct   = 0;
   int active_items   = 0;
   int write_count    = 0;
   int start_count    = 0;
   int run_tick_count = 0;
   int finished_runs  = 0;
   int rsp_count      = 0;
   int mismatches     = 0;
   int stall_cycles   = 0;

   // The bring-up program starts at the top of the store so that the pointer wraps to
   // address zero part way through. It pulls the line low for two ticks, waits one tick
   // in an undefined mode, samples two high levels and then ends; the end instruction is
   // written while the program is already running.
   script_row_type bring_up [BRING_UP_ROWS] = '{
      '{OP_TICK,  8'h00, 8'h00,        1'b1, 1'b1, IDLE_STATUS},    // tick while idle
      '{OP_NOP,   8'hFF, 8'hFF,        1'b1, 1'b1, IDLE_STATUS},    // no operation
      '{OP_WRITE, 8'hFD, MODE_PULL,    1'b0, 1'b0, NO_STATUS},
      '{OP_WRITE, 8'hFE, 8'h00,        1'b0, 1'b0, NO_STATUS},
      '{OP_WRITE, 8'hFF, 8'h02,        1'b0, 1'b0, NO_STATUS},
      '{OP_WRITE, 8'h00, 8'hFF,        1'b1, 1'b0, NO_STATUS},      // undefined mode
      '{OP_WRITE, 8'h01, 8'h00,        1'b1, 1'b0, NO_STATUS},
      '{OP_WRITE, 8'h02, 8'h01,        1'b1, 1'b0, NO_STATUS},
      '{OP_WRITE, 8'h03, MODE_SAMPLE,  1'b0, 1'b0, NO_STATUS},
      '{OP_WRITE, 8'h04, 8'h00,        1'b0, 1'b0, NO_STATUS},
      '{OP_WRITE, 8'h05, 8'h02,        1'b0, 1'b0, NO_STATUS},
      '{OP_START, 8'hFD, 8'h00,        1'b0, 1'b1, STARTED_STATUS},
      '{OP_TICK,  8'h00, 8'h00,        1'b0, 1'b0, NO_STATUS},      // fetch, pointer wraps
      '{OP_TICK,  8'h00, 8'h00,        1'b1, 1'b0, NO_STATUS},
      '{OP_TICK,  8'h00, 8'h00,        1'b0, 1'b0, NO_STATUS},      // pull ends
      '{OP_WRITE, 8'h06, MODE_END,     1'b0, 1'b0, NO_STATUS},      // write while running
      '{OP_WRITE, 8'h07, 8'hFF,        1'b0, 1'b0, NO_STATUS},
      '{OP_WRITE, 8'h08, 8'hFF,        1'b0, 1'b0, NO_STATUS},
      '{OP_TICK,  8'h00, 8'h00,        1'b0, 1'b0, NO_STATUS},      // fetch, wait
      '{OP_TICK,  8'h00, 8'h00,        1'b0, 1'b0, NO_STATUS},
      '{OP_TICK,  8'h00, 8'h00,        1'b0, 1'b0, NO_STATUS},      // fetch, sample
      '{OP_TICK,  8'h00, 8'h00,        1'b1, 1'b0, NO_STATUS},
      '{OP_TICK,  8'h00, 8'h00,        1'b1, 1'b0, NO_STATUS},
      '{OP_TICK,  8'h00, 8'h00,        1'b0, 1'b0, NO_STATUS},      // fetch, end
      '{OP_TICK,  8'h00, 8'h00,        1'b0, 1'b0, NO_STATUS}       // run finishes
   };

   // Advances the shadow by one accepted request and returns the response it should cause.
   function automatic line_status_type step_sequencer(op_type op, logic [7:0] addr,
                                                      logic [7:0] data, logic level);
      logic ended;
      logic [7:0] hi_byte;
      ended = 1'b0;
      case (op)
         OP_WRITE: begin
            prog_mem[addr]     = data;
            prog_written[addr] = 1'b1;
            write_count++;
            active_items++;
         end
         OP_START: begin
            // A start while running simply restarts; counters, drive and presence stay.
            pc         = addr;
            run_active = 1'b1;
            instr_held = 1'b0;
            start_count++;
            active_items++;
         end
         OP_TICK: begin
            if (run_active) begin
               run_tick_count++;
               active_items++;
               if (!instr_held) begin
                  // The fetching tick just loads mode and count and clears sample counters.
                  mode_reg   = prog_mem[pc];
                  pc         = pc + 8'd1;
                  hi_byte    = prog_mem[pc];
                  pc         = pc + 8'd1;
                  tick_count = {hi_byte, prog_mem[pc]};
                  pc         = pc + 8'd1;
                  if (mode_reg == MODE_SAMPLE) begin
                     low_cnt  = '0;
                     high_cnt = '0;
                  end
                  instr_held = 1'b1;
               end else begin
                  case (mode_reg)
                     MODE_END: begin
                        presence_bit = (high_cnt > low_cnt);
                        run_active   = 1'b0;
                        ended        = 1'b1;
                        finished_runs++;
                     end
                     MODE_PULL:    line_rel = 1'b0;
                     MODE_RELEASE: line_rel = 1'b1;
                     MODE_SAMPLE: begin
                        line_rel = 1'b1;
                        if (level) begin
                           if (high_cnt != COUNT_MAX) high_cnt = high_cnt + 16'd1;
                        end else begin
                           if (low_cnt != COUNT_MAX) low_cnt = low_cnt + 16'd1;
                        end
                     end
                     default: ;
                  endcase
                  // A count of zero wraps to all ones here, hence 65536 ticks.
                  tick_count = tick_count - 16'd1;
                  if (tick_count == 16'd0 || ended) instr_held = 1'b0;
               end
            end
         end
         default: ;
      endcase
      return '{line_rel, run_active, ended, presence_bit};
   endfunction

   // Presents one request transaction and returns at the edge where it is taken. The
   // sender idles at random beforehand; valid is left high for a following transaction.
   task automatic drive_request(op_type op, logic [7:0] addr, logic [7:0] data,
                                logic level);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= op;
      req_bus.address    <= addr;
      req_bus.data       <= data;
      req_bus.line_level <= level;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic issue(op_type op, logic [7:0] addr, logic [7:0] data, logic level);
      drive_request(op, addr, data, level);
      expected_status_q.push_back(step_sequencer(op, addr, data, level));
   endtask

   function automatic logic [7:0] random_mode();
      int pick;
      pick = $urandom_range(9);
      if (pick < 3) return MODE_PULL;
      if (pick < 6) return MODE_RELEASE;
      if (pick < 9) return MODE_SAMPLE;
      return 8'($urandom);
   endfunction

   // Mostly a handful of ticks; now and then a few hundred.
   function automatic logic [15:0] random_count();
      if ($urandom_range(19) == 0) return {8'h01, 8'($urandom)};
      return {8'h00, 8'($urandom_range(1, 6))};
   endfunction

   task automatic write_instruction(logic [7:0] cursor, logic [7:0] mode,
                                    logic [15:0] count);
      issue(OP_WRITE, cursor,        mode,         1'($urandom));
      issue(OP_WRITE, cursor + 8'd1, count[15:8],  1'($urandom));
      issue(OP_WRITE, cursor + 8'd2, count[7:0],   1'($urandom));
   endtask

   // Sends one tick. If that tick would fetch bytes that were never written, a random
   // instruction is written into the gaps first.
   task automatic tick_line(logic level);
      logic [7:0]  spot;
      logic [23:0] filler;
      if (run_active && !instr_held) begin
         filler = {random_mode(), random_count()};
         spot   = pc;
         for (int k = 0; k < 3; k++) begin
            if (!prog_written[spot]) issue(OP_WRITE, spot, filler[23 - 8*k -: 8], level);
            spot = spot + 8'd1;
         end
      end
      issue(OP_TICK, 8'($urandom), 8'($urandom), level);
   endtask

   // A short well-formed program at a random place, then ticks until it ends, with some
   // noise mixed in: no-operations, stray writes and restarts while running.
   task automatic run_program_episode();
      logic [7:0] base;
      logic [7:0] cursor;
      int n_instr;
      int steps;
      int roll;
      base    = 8'($urandom);
      n_instr = $urandom_range(1, 4);
      cursor  = base;
      for (int i = 0; i < n_instr; i++) begin
         write_instruction(cursor, random_mode(), random_count());
         cursor = cursor + 8'd3;
      end
      write_instruction(cursor, MODE_END, 16'($urandom));
      issue(OP_START, base, 8'($urandom), 1'($urandom));
      steps = 0;
      while (run_active && steps < EPISODE_STEPS) begin
         roll = $urandom_range(99);
         if (roll < 82) tick_line(1'($urandom));
         else if (roll < 88) issue(OP_NOP, 8'($urandom), 8'($urandom), 1'($urandom));
         else if (roll < 95) issue(OP_WRITE, 8'($urandom), 8'($urandom), 1'($urandom));
         else issue(OP_START, base, 8'($urandom), 1'($urandom));
         steps++;
      end
      // Ticks on an idle sequencer are ignored by the block but still answered.
      if (!run_active && $urandom_range(2) == 0)
         issue(OP_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
   endtask

   task automatic run_random_phase(int req_pct, int rsp_pct);
      int goal;
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      goal         = active_items + PHASE_ITEMS;
      while (active_items < goal) run_program_episode();
   endtask

   // The receiver takes or refuses responses at random, at the rate of the current phase.
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   task automatic flag_field(string field, logic want, logic got);
      if (want !== got) begin
         if (mismatches < REPORT_LIMIT)
            $error("%s: expected %0b, actual %0b", field, want, got);
         mismatches++;
      end
   endtask

   // Every response transaction is matched against the oldest outstanding prediction.
   always @(posedge clock) begin : response_check
      line_status_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_count++;
         if (expected_status_q.size() == 0) begin
            if (mismatches < REPORT_LIMIT)
               $error("response transaction with no request outstanding");
            mismatches++;
         end else begin
            want = expected_status_q.pop_front();
            flag_field("line_released", want.line_released, rsp_bus.line_released);
            flag_field("busy_res",      want.busy_res,      rsp_bus.busy_res);
            flag_field("finished",      want.finished,      rsp_bus.finished);
            flag_field("presence",      want.presence,      rsp_bus.presence);
         end
      end
   end

   // The watchdog only counts cycles in which neither channel moves a transaction; a hung
   // block or a lost response trips it.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles, %0d responses outstanding",
                  STALL_LIMIT, expected_status_q.size());
         $display("one_wire_tick_program_sequencer: mismatch");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      req_bus.valid      = 1'b0;
      req_bus.opcode     = OP_NOP;
      req_bus.address    = '0;
      req_bus.data       = '0;
      req_bus.line_level = 1'b0;
      rsp_bus.ready      = 1'b0;
      foreach (prog_written[i]) prog_written[i] = 1'b0;
      foreach (prog_mem[i]) prog_mem[i] = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Bring-up script first, under the first idling pattern.
      req_idle_pct = 30;
      rsp_idle_pct = 87;
      for (int row = 0; row < BRING_UP_ROWS; row++) begin
         drive_request(bring_up[row].op, bring_up[row].addr, bring_up[row].data,
                       bring_up[row].level);
         if (bring_up[row].typed) begin
            void'(step_sequencer(bring_up[row].op, bring_up[row].addr,
                                 bring_up[row].data, bring_up[row].level));
            expected_status_q.push_back(bring_up[row].status);
         end else begin
            expected_status_q.push_back(step_sequencer(bring_up[row].op,
                                                       bring_up[row].addr,
                                                       bring_up[row].data,
                                                       bring_up[row].level));
         end
      end

      // Random programs: slow receiver, then slow sender, then full rate.
      run_random_phase(30, 87);
      run_random_phase(87, 30);
      run_random_phase(0, 0);

      req_bus.valid <= 1'b0;
      while (expected_status_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d writes, %0d starts and %0d ticks on a running program;",
               write_count, start_count, run_tick_count);
      $display("%0d responses checked and %0d runs finished under three idling patterns",
               rsp_count, finished_runs);
      if (mismatches == 0) begin
         $display("one_wire_tick_program_sequencer: match");
      end else begin
         $display("one_wire_tick_program_sequencer: mismatch");
      end
      $finish;
   end

endmodule
